/* hw/rtl/cfr_pkg.sv */
// Shared types and constants of the command frame receiver.
// Used by cfr_ctrl, cfr_datapath, command_frame_receiver_core and cfr_checker; no dependencies.
package cfr_pkg;

	localparam int unsigned StoreDepth = 9;
	localparam int unsigned IdxW       = 4;
	localparam int unsigned TdataOutW  = 40;

	localparam logic [7:0] ChHash   = 8'h23;
	localparam logic [7:0] ChNl     = 8'h0A;
	localparam logic [7:0] ChBslash = 8'h5C;
	localparam logic [7:0] ChZero   = 8'h30;
	localparam logic [7:0] ChNine   = 8'h39;
	localparam logic [7:0] ChOne    = 8'h31;
	localparam logic [7:0] ChTwo    = 8'h32;
	localparam logic [7:0] ChThree  = 8'h33;

	typedef enum logic [2:0] {
		ERR_NOT_HASH    = 3'd0,
		ERR_NOT_DIGIT   = 3'd1,
		ERR_NOT_LETTER  = 3'd2,
		ERR_BAD_ESCAPE  = 3'd3,
		ERR_NOT_NEWLINE = 3'd4
	} err_code_t;

	typedef enum logic [2:0] {
		ST_WAIT,
		ST_SIZE,
		ST_CMD,
		ST_DATA,
		ST_ESC,
		ST_END,
		ST_DUMP
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic      load_expected;
		logic      load_command;
		logic      clear_received;
		logic      store;
		logic      store_escaped;
		logic      emit_error;
		err_code_t error_code;
		logic      emit_empty;
		logic      start_dump;
		logic      dump_step;
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_hash;
		logic is_digit;
		logic is_letter;
		logic is_bslash;
		logic is_esc_code;
		logic is_newline;
		logic exp_zero;
		logic store_full;
		logic dump_last;
		logic out_free;
	} dp_status_t;

endpackage

/* hw/rtl/cfr_ctrl.sv */
// Frame parser state machine: decides each transaction's effect and drives the datapath.
// Depends on cfr_pkg.
module cfr_ctrl
	import cfr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output ctl_cmd_t   cmd
);

	state_t state_q;
	state_t state_d;
	logic   fire;

	assign in_ready = (state_q != ST_DUMP) && status.out_free;
	assign fire     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_WAIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_WAIT: begin
				if (fire && status.is_hash) begin
					state_d = ST_SIZE;
				end
			end
			ST_SIZE: begin
				if (fire) begin
					state_d = status.is_digit ? ST_CMD : ST_WAIT;
				end
			end
			ST_CMD: begin
				if (fire) begin
					if (!status.is_letter) begin
						state_d = ST_WAIT;
					end else if (status.exp_zero) begin
						state_d = ST_END;
					end else begin
						state_d = ST_DATA;
					end
				end
			end
			ST_DATA: begin
				if (fire) begin
					if (status.is_bslash) begin
						state_d = ST_ESC;
					end else begin
						state_d = status.store_full ? ST_END : ST_DATA;
					end
				end
			end
			ST_ESC: begin
				if (fire) begin
					if (!status.is_esc_code) begin
						state_d = ST_WAIT;
					end else begin
						state_d = status.store_full ? ST_END : ST_DATA;
					end
				end
			end
			ST_END: begin
				if (fire) begin
					if (status.is_newline && !status.exp_zero) begin
						state_d = ST_DUMP;
					end else begin
						state_d = ST_WAIT;
					end
				end
			end
			ST_DUMP: begin
				if (status.out_free && status.dump_last) begin
					state_d = ST_WAIT;
				end
			end
			default: begin
				state_d = ST_WAIT;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.error_code = ERR_NOT_HASH;
		case (state_q)
			ST_WAIT: begin
				if (fire && !status.is_hash) begin
					cmd.emit_error = 1'b1;
					cmd.error_code = ERR_NOT_HASH;
				end
			end
			ST_SIZE: begin
				if (fire) begin
					cmd.load_expected = status.is_digit;
					cmd.emit_error    = !status.is_digit;
					cmd.error_code    = ERR_NOT_DIGIT;
				end
			end
			ST_CMD: begin
				if (fire) begin
					cmd.load_command   = status.is_letter;
					cmd.clear_received = status.is_letter && !status.exp_zero;
					cmd.emit_error     = !status.is_letter;
					cmd.error_code     = ERR_NOT_LETTER;
				end
			end
			ST_DATA: begin
				if (fire) begin
					cmd.store = !status.is_bslash;
				end
			end
			ST_ESC: begin
				if (fire) begin
					cmd.store         = status.is_esc_code;
					cmd.store_escaped = 1'b1;
					cmd.emit_error    = !status.is_esc_code;
					cmd.error_code    = ERR_BAD_ESCAPE;
				end
			end
			ST_END: begin
				if (fire) begin
					cmd.emit_error = !status.is_newline;
					cmd.error_code = ERR_NOT_NEWLINE;
					cmd.emit_empty = status.is_newline && status.exp_zero;
					cmd.start_dump = status.is_newline && !status.exp_zero;
				end
			end
			ST_DUMP: begin
				cmd.dump_step = status.out_free;
			end
			default: begin
				cmd.emit_error = fire && !status.is_hash;
				cmd.error_code = ERR_NOT_HASH;
			end
		endcase
	end

endmodule

/* hw/rtl/cfr_datapath.sv */
// Datapath of the frame receiver: byte classifier, counters, data store, output register.
// Depends on cfr_pkg; driven by cfr_ctrl.
module cfr_datapath
	import cfr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           rx_byte,
	input  ctl_cmd_t             cmd,
	output dp_status_t           status,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [TdataOutW-1:0] out_data,
	output logic                 out_error,
	output logic                 out_last
);

	logic [IdxW-1:0] expected_q;
	logic [IdxW-1:0] received_q;
	logic [IdxW-1:0] rd_idx_q;
	logic [7:0]      command_q;
	logic [7:0]      store_q [StoreDepth];

	logic            out_valid_q;
	logic            out_error_q;
	logic            out_last_q;
	err_code_t       out_code_q;
	logic [7:0]      out_bad_q;
	logic [7:0]      out_cmd_q;
	logic [IdxW-1:0] out_len_q;
	logic [IdxW-1:0] out_idx_q;
	logic [7:0]      out_byte_q;

	logic            room;
	logic [IdxW-1:0] received_next;
	logic [7:0]      esc_byte;
	logic [7:0]      store_byte;
	logic            load_out;

	assign room          = received_q < IdxW'(StoreDepth);
	assign received_next = room ? received_q + 1'b1 : received_q;

	always_comb begin
		case (rx_byte)
			ChZero:  esc_byte = 8'h00;
			ChOne:   esc_byte = ChHash;
			ChTwo:   esc_byte = ChNl;
			ChThree: esc_byte = ChBslash;
			default: esc_byte = 8'h00;
		endcase
	end

	assign store_byte = cmd.store_escaped ? esc_byte : rx_byte;

	assign status.is_hash     = rx_byte == ChHash;
	assign status.is_digit    = (rx_byte >= ChZero) && (rx_byte <= ChNine);
	assign status.is_letter   = ((rx_byte >= 8'h61) && (rx_byte <= 8'h7A)) ||
		((rx_byte >= 8'h41) && (rx_byte <= 8'h5A));
	assign status.is_bslash   = rx_byte == ChBslash;
	assign status.is_esc_code = (rx_byte >= ChZero) && (rx_byte <= ChThree);
	assign status.is_newline  = rx_byte == ChNl;
	assign status.exp_zero    = expected_q == '0;
	assign status.store_full  = received_next >= expected_q;
	assign status.dump_last   = rd_idx_q == expected_q - 1'b1;
	assign status.out_free    = !out_valid_q || out_ready;

	assign load_out = cmd.emit_error || cmd.emit_empty || cmd.dump_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q  <= '0;
			received_q  <= '0;
			rd_idx_q    <= '0;
			command_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_expected) begin
				expected_q <= IdxW'(rx_byte - ChZero);
			end
			if (cmd.load_command) begin
				command_q <= rx_byte;
			end
			if (cmd.clear_received) begin
				received_q <= '0;
			end else if (cmd.store) begin
				received_q <= received_next;
			end
			if (cmd.start_dump) begin
				rd_idx_q <= '0;
			end else if (cmd.dump_step) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// drop a write that would fall past the end of the store
	always_ff @(posedge clk) begin
		if (cmd.store && room) begin
			store_q[received_q] <= store_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_error_q <= cmd.emit_error;
			out_last_q  <= cmd.emit_error || cmd.emit_empty || status.dump_last;
			out_code_q  <= cmd.emit_error ? cmd.error_code : ERR_NOT_HASH;
			out_bad_q   <= cmd.emit_error ? rx_byte : 8'h00;
			out_cmd_q   <= cmd.emit_error ? 8'h00 : command_q;
			out_len_q   <= cmd.dump_step ? expected_q : '0;
			out_idx_q   <= cmd.dump_step ? rd_idx_q : '0;
			out_byte_q  <= cmd.dump_step ? store_q[rd_idx_q] : 8'h00;
		end
	end

	assign out_valid = out_valid_q;
	assign out_error = out_error_q;
	assign out_last  = out_last_q;
	assign out_data  = {5'b0, out_byte_q, out_idx_q, out_len_q, out_cmd_q, out_bad_q,
		out_code_q};

endmodule

/* hw/rtl/command_frame_receiver_core.sv */
// Command frame receiver: byte stream in, decoded frame and error items out.
// Usage:
//   Slave channel: one received link byte per transaction on s_tdata.
//   Master channel: one item per transaction; m_tuser flags an error item,
//   m_tlast marks the final item caused by one input byte.
//   A frame is '#', a length digit, a command letter, the data bytes
//   (backslash escapes 0..3 for zero, '#', newline, backslash) and newline.
// Order: error and empty-frame items are registered and show on m_tvalid the
//   cycle after the byte's transaction; the first item of a frame with data
//   follows its newline through the ST_DUMP state and then the output register.
// Throughput: one byte per cycle outside a dump while the output register is free
//   or being drained. On the closing newline of a frame with n data bytes the
//   store is read out one entry per cycle while m_tready allows, and s_tready
//   stays low until the last entry is loaded; the single store read port sets that pace.
// Stall: with m_tready low the output register holds its item and s_tready
//   stays low while that item waits, whatever the next byte is.
// Reset: arst_n returns the parser to waiting for '#' and empties the output;
//   no clearing pass is needed.
// Depends on cfr_pkg, cfr_ctrl and cfr_datapath.
module command_frame_receiver_core
	import cfr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [7:0] rx_byte
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [2:0] error_code, [10:3] bad_byte, [18:11] command, [22:19] data_length,
	// [26:23] data_index, [34:27] data_byte, [39:35] zero
	output logic [TdataOutW-1:0] m_tdata,
	output logic                 m_tuser,   // [0] is_error
	output logic                 m_tlast
);

	ctl_cmd_t   cmd;
	dp_status_t status;

	cfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	cfr_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_byte   (s_tdata),
		.cmd       (cmd),
		.status    (status),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_error (m_tuser),
		.out_last  (m_tlast)
	);

endmodule

/* hw/rtl/cfr_checker.sv */
// Port-level checks of command_frame_receiver_core, attached by bind.
// Depends on cfr_pkg for the output width.
module cfr_checker
	import cfr_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [TdataOutW-1:0] m_tdata,
	input logic                 m_tuser,
	input logic                 m_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output transaction changed while stalled");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && (m_tdata[2:0] <= 3'd4))
		else $error("error item not last or bad code");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser && (m_tdata[22:19] != 4'd0) |->
		(m_tdata[26:23] < m_tdata[22:19]))
		else $error("data index beyond length");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser && (m_tdata[22:19] != 4'd0) |->
		(m_tlast == (m_tdata[26:23] == m_tdata[22:19] - 4'd1)))
		else $error("last flag not on final data item");

endmodule

bind command_frame_receiver_core cfr_checker u_cfr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
